@@ hw/rtl/pnp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the peak normalize percent unit.
// Used by the controller, the datapath, the top level and the checker.
package pnp_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned SmpW     = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned PosW     = 10;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ProdW    = SmpW + PctW;
  localparam int unsigned DivSteps = PctW;
  localparam logic [PctW-1:0] PctScale = PctW'(100);

  typedef enum logic [ModeW-1:0] {
    ModeLoad    = 2'd0,
    ModeRead    = 2'd1,
    ModeRestart = 2'd2,
    ModeUnused  = 2'd3
  } mode_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_start;
    logic div_init;
    logic div_step;
    logic emit;
    logic emit_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_data;
  } dp_stat_t;

endpackage

@@ hw/rtl/pnp_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pnp_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: decodes input beats, sequences read, divide and emit steps.
// Depends on pnp_pkg; drives the datapath through pnp_pkg::ctrl_cmd_t.
module pnp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [pnp_pkg::ModeW-1:0] mode_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  pnp_pkg::dp_stat_t       stat_i,
  output pnp_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiv,
    StEmit,
    StEmpty
  } state_e;

  localparam int unsigned StepW = $clog2(pnp_pkg::DivSteps);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;
  logic             slot_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (mode_i)
            pnp_pkg::ModeLoad: begin
              cmd_o.load = 1'b1;
            end
            pnp_pkg::ModeRead: begin
              if (stat_i.has_data) begin
                cmd_o.rd_start = 1'b1;
                state_d        = StRead;
              end else begin
                state_d = StEmpty;
              end
            end
            pnp_pkg::ModeRestart: begin
              cmd_o.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepW'(pnp_pkg::DivSteps - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // hold until the output register can take the beat
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StEmpty: begin
        if (slot_free) begin
          cmd_o.emit_empty = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pnp_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: sample store, count, read index, peak, scale and bit-serial divide.
// Depends on pnp_pkg and pnp_ram; commanded by pnp_ctrl.
module pnp_datapath #(
  parameter int unsigned Depth = pnp_pkg::DefDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pnp_pkg::ctrl_cmd_t        cmd_i,
  output pnp_pkg::dp_stat_t         stat_o,
  input  logic [pnp_pkg::SmpW-1:0]  sample_i,
  output logic [pnp_pkg::PctW-1:0]  percent_o,
  output logic [pnp_pkg::PosW-1:0]  position_o,
  output logic                      is_last_o,
  output logic                      empty_res_o
);

  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned PosExtW = (CntW > pnp_pkg::PosW) ? CntW : pnp_pkg::PosW;
  localparam int unsigned SmpW    = pnp_pkg::SmpW;
  localparam int unsigned PctW    = pnp_pkg::PctW;
  localparam int unsigned ProdW   = pnp_pkg::ProdW;

  logic [CntW-1:0]    count_q, rdidx_q;
  logic [SmpW-1:0]    peak_q;
  logic [SmpW-1:0]    rdata;
  logic [ProdW-1:0]   prod;
  logic [SmpW-1:0]    rem_q;
  logic [PctW-1:0]    low_q, quo_q;
  logic [SmpW:0]      trial;
  logic               fits;
  logic               full;
  logic               wr_en;
  logic [PosExtW-1:0] idx_ext;

  logic [PctW-1:0]        percent_q;
  logic [pnp_pkg::PosW-1:0] position_q;
  logic                   is_last_q, empty_q;

  assign full   = (count_q == CntW'(Depth));
  assign wr_en  = cmd_i.load && !full;
  assign stat_o.has_data = (rdidx_q < count_q);

  pnp_ram #(
    .Width(SmpW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(sample_i),
    .re_i   (cmd_i.rd_start),
    .raddr_i(rdidx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rdidx_q <= '0;
      peak_q  <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      rdidx_q <= '0;
      peak_q  <= '0;
    end else begin
      if (wr_en) begin
        count_q <= count_q + 1'b1;
        if (sample_i > peak_q) begin
          peak_q <= sample_i;
        end
      end
      if (cmd_i.emit) begin
        rdidx_q <= rdidx_q + 1'b1;
      end
    end
  end

  // sample <= peak, so the quotient fits in PctW bits and the top of the
  // product is already below the divisor
  assign prod  = ProdW'(rdata) * ProdW'(pnp_pkg::PctScale);
  assign trial = {rem_q, low_q[PctW-1]};
  assign fits  = (trial >= {1'b0, peak_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= prod[ProdW-1:PctW];
      low_q <= prod[PctW-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? SmpW'(trial - {1'b0, peak_q}) : trial[SmpW-1:0];
      low_q <= {low_q[PctW-2:0], 1'b0};
      quo_q <= {quo_q[PctW-2:0], fits};
    end
  end

  assign idx_ext = PosExtW'(rdidx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      percent_q  <= (peak_q == '0) ? '0 : quo_q;
      position_q <= idx_ext[pnp_pkg::PosW-1:0];
      is_last_q  <= (CntW'(rdidx_q + 1'b1) == count_q);
      empty_q    <= 1'b0;
    end else if (cmd_i.emit_empty) begin
      percent_q  <= '0;
      position_q <= '0;
      is_last_q  <= 1'b0;
      empty_q    <= 1'b1;
    end
  end

  assign percent_o   = percent_q;
  assign position_o  = position_q;
  assign is_last_o   = is_last_q;
  assign empty_res_o = empty_q;

endmodule

@@ hw/rtl/peak_normalize_percent_unit.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | mode_i[1:0], sample_i[7:0]
// out     | output    | out_valid_o/out_ready_i | percent_o[6:0], position_o[9:0],
//         |           |                       | is_last_o, empty_res_o
// Load, restart and unused-mode beats are handled without leaving the idle state.
// A readout runs store read, scale by 100, 7 divide steps of the restoring
// divider, then the output register load.
// A readout with nothing left skips the divider and loads an empty result beat.
// Reset clears count, read position, peak and output valid; store needs no clear.
// A full output register stalls the block only where it loads a result or empty beat.
// Top level; depends on pnp_pkg, pnp_ctrl, pnp_datapath and pnp_ram.
module peak_normalize_percent_unit #(
  parameter int unsigned Depth = pnp_pkg::DefDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pnp_pkg::ModeW-1:0] mode_i,
  input  logic [pnp_pkg::SmpW-1:0]  sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pnp_pkg::PctW-1:0]  percent_o,
  output logic [pnp_pkg::PosW-1:0]  position_o,
  output logic                      is_last_o,
  output logic                      empty_res_o
);

  pnp_pkg::ctrl_cmd_t cmd;
  pnp_pkg::dp_stat_t  stat;

  pnp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pnp_datapath #(
    .Depth(Depth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .sample_i   (sample_i),
    .percent_o  (percent_o),
    .position_o (position_o),
    .is_last_o  (is_last_o),
    .empty_res_o(empty_res_o)
  );

endmodule

@@ hw/rtl/pnp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for peak_normalize_percent_unit, attached by bind.
// Depends on pnp_pkg.
module pnp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [pnp_pkg::ModeW-1:0] mode_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [pnp_pkg::PctW-1:0]  percent_o,
  input logic [pnp_pkg::PosW-1:0]  position_o,
  input logic                      is_last_o,
  input logic                      empty_res_o
);

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (percent_o <= pnp_pkg::PctScale))
    else $error("percent above full scale");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |->
      (percent_o == '0 && position_o == '0 && !is_last_o))
    else $error("empty beat carries nonzero fields");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == pnp_pkg::ModeRead) |=> !in_ready_o)
    else $error("input taken while readout in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(percent_o) && $stable(position_o)
       && $stable(is_last_o) && $stable(empty_res_o)))
    else $error("stalled output beat changed");

endmodule

bind peak_normalize_percent_unit pnp_checker u_pnp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .mode_i     (mode_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .percent_o  (percent_o),
  .position_o (position_o),
  .is_last_o  (is_last_o),
  .empty_res_o(empty_res_o)
);

@@ dv/pnp_norm_sb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the peak normalize percent unit: mirrors the sample store,
// count, read position and peak, and checks each readout beat in order.
// Depends on pnp_pkg for the mode codes and field widths.
package pnp_norm_sb_pkg;
  import pnp_pkg::*;

  typedef struct packed {
    logic [PctW-1:0] percent;
    logic [PosW-1:0] position;
    logic            is_last;
    logic            empty_res;
  } norm_result_t;

  class norm_scoreboard;
    logic [SmpW-1:0] mirror_store [DefDepth];
    int unsigned     loaded_cnt;
    int unsigned     next_rd;
    logic [SmpW-1:0] peak_seen;
    norm_result_t    expected_q [$];
    int unsigned     errors;
    int unsigned     n_load, n_read, n_restart, n_empty, n_dropped, n_checked;

    function new();
      loaded_cnt = 0;
      next_rd    = 0;
      peak_seen  = '0;
      errors     = 0;
      n_load     = 0;
      n_read     = 0;
      n_restart  = 0;
      n_empty    = 0;
      n_dropped  = 0;
      n_checked  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update the mirror for one accepted input beat; queue the readout it causes.
    function void note_beat(mode_e mode, logic [SmpW-1:0] smp);
      norm_result_t res;
      int unsigned  scaled;
      res = '0;
      case (mode)
        ModeLoad: begin
          n_load++;
          if (loaded_cnt < DefDepth) begin
            mirror_store[loaded_cnt] = smp;
            loaded_cnt++;
            if (smp > peak_seen) peak_seen = smp;
          end else begin
            n_dropped++;
          end
        end
        ModeRead: begin
          n_read++;
          if (next_rd < loaded_cnt) begin
            scaled = 0;
            if (peak_seen != '0) begin
              scaled = (32'(mirror_store[next_rd]) * 32'(PctScale)) / 32'(peak_seen);
            end
            res.percent  = PctW'(scaled);
            res.position = PosW'(next_rd);
            res.is_last  = (next_rd + 1 == loaded_cnt);
            next_rd++;
          end else begin
            res.empty_res = 1'b1;
            n_empty++;
          end
          expected_q.push_back(res);
        end
        ModeRestart: begin
          n_restart++;
          loaded_cnt = 0;
          next_rd    = 0;
          peak_seen  = '0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(norm_result_t got);
      norm_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected: %p", got));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.percent !== want.percent)
        report_mismatch($sformatf("percent at position %0d: got %0d, expected %0d",
                                  want.position, got.percent, want.percent));
      if (got.position !== want.position)
        report_mismatch($sformatf("position: got %0d, expected %0d",
                                  got.position, want.position));
      if (got.is_last !== want.is_last)
        report_mismatch($sformatf("is_last at position %0d: got %b, expected %b",
                                  want.position, got.is_last, want.is_last));
      if (got.empty_res !== want.empty_res)
        report_mismatch($sformatf("empty_res at position %0d: got %b, expected %b",
                                  want.position, got.empty_res, want.empty_res));
    endtask
  endclass

endpackage

@@ dv/tb_peak_normalize_percent_unit.sv @@
`timescale 1ns / 1ps
// Top of the testbench for peak_normalize_percent_unit: directed and random
// load/readout/restart traffic with random idling on both channels.
// Depends on pnp_pkg, pnp_norm_sb_pkg and the RTL of the unit.
module tb_peak_normalize_percent_unit;
  import pnp_pkg::*;
  import pnp_norm_sb_pkg::*;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [ModeW-1:0]  mode_i      = '0;
  logic [SmpW-1:0]   sample_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PctW-1:0]   percent_o;
  logic [PosW-1:0]   position_o;
  logic              is_last_o;
  logic              empty_res_o;

  bit                steady     = 1'b0;
  int unsigned       beats_sent = 0;
  norm_scoreboard    sb;

  peak_normalize_percent_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .percent_o   (percent_o),
    .position_o  (position_o),
    .is_last_o   (is_last_o),
    .empty_res_o (empty_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d results still outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Result sink: check each accepted beat, stall at random outside steady stretches.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({percent_o, position_o, is_last_o, empty_res_o});
    end
    out_ready_i <= steady || ($urandom_range(99) >= 22);
  end

  task automatic send_beat(input mode_e m, input logic [SmpW-1:0] s);
    if (!steady) begin
      while ($urandom_range(99) < 22) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_beat(m, s);
    if (m != ModeUnused) beats_sent++;
  endtask

  // Hold off the sender until every outstanding readout has come back.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SmpW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SmpW'(0);
      1:       return SmpW'(255);
      2:       return SmpW'($urandom_range(1, 3));
      default: return SmpW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [SmpW-1:0] any_byte();
    return SmpW'($urandom_range(255));
  endfunction

  // One load-then-readout sequence with random content, some noise and
  // occasional early cut-off of the readouts.
  task automatic play_burst(input int unsigned n);
    int unsigned k;
    int unsigned reads;
    bit          flat;
    flat = ($urandom_range(11) == 0);
    if ($urandom_range(9) != 0) send_beat(ModeRestart, any_byte());
    for (k = 0; k < n; k++) begin
      send_beat(ModeLoad, flat ? SmpW'(0) : pick_sample());
      if ($urandom_range(7) == 0) send_beat(ModeRead, any_byte());
      if ($urandom_range(19) == 0) send_beat(ModeUnused, any_byte());
    end
    reads = n + $urandom_range(2);
    if ($urandom_range(7) == 0) reads = $urandom_range(n);
    for (k = 0; k < reads; k++) begin
      send_beat(ModeRead, any_byte());
    end
  endtask

  // Fill the whole store, push two loads past it, then read the front of it back.
  task automatic fill_store();
    int unsigned k;
    send_beat(ModeRestart, any_byte());
    for (k = 0; k < DefDepth; k++) begin
      send_beat(ModeLoad, SmpW'($urandom_range(1, 200)));
    end
    send_beat(ModeLoad, SmpW'(255));
    send_beat(ModeLoad, SmpW'(255));
    for (k = 0; k < 300; k++) begin
      send_beat(ModeRead, any_byte());
    end
  endtask

  initial begin
    int unsigned burst_no;
    int unsigned guard;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty readout, unused mode, zero peak, extremes, late load.
    send_beat(ModeRestart, SmpW'(255));
    send_beat(ModeRead, SmpW'(8'hA5));
    send_beat(ModeUnused, SmpW'(255));
    send_beat(ModeLoad, SmpW'(0));
    send_beat(ModeRead, SmpW'(0));
    send_beat(ModeRead, SmpW'(0));
    send_beat(ModeRestart, SmpW'(0));
    send_beat(ModeLoad, SmpW'(255));
    send_beat(ModeLoad, SmpW'(0));
    send_beat(ModeLoad, SmpW'(128));
    send_beat(ModeLoad, SmpW'(1));
    repeat (4) send_beat(ModeRead, SmpW'(0));
    wait_results_done();
    send_beat(ModeRestart, SmpW'(0));
    send_beat(ModeLoad, SmpW'(100));
    send_beat(ModeLoad, SmpW'(50));
    send_beat(ModeRead, SmpW'(0));
    send_beat(ModeLoad, SmpW'(200));
    send_beat(ModeRead, SmpW'(0));
    send_beat(ModeRead, SmpW'(0));
    send_beat(ModeRead, SmpW'(0));
    send_beat(ModeUnused, SmpW'(0));

    burst_no = 0;
    while (beats_sent < 450) begin
      steady = (burst_no >= 2 && burst_no < 8);
      play_burst($urandom_range(3) == 0 ? $urandom_range(25, 60) : $urandom_range(1, 24));
      burst_no++;
    end
    steady = 1'b0;
    wait_results_done();
    fill_store();
    while (beats_sent < 1800) begin
      play_burst($urandom_range(1, 24));
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    end

    $display("Run covered %0d loads (%0d past a full store), %0d readouts (%0d empty),",
             sb.n_load, sb.n_dropped, sb.n_read, sb.n_empty);
    $display("%0d restarts; %0d result beats checked, %0d mismatches.",
             sb.n_restart, sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
